/* rtl/core/assert_macros.svh */
// Assertion macros shared by the pulse gesture classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside of reset.
`define PGC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pgc_pkg.sv */
// Package with the types, codes and reset values of the pulse gesture classifier.
package pgc_pkg;

  // Default width of one encoder count.
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  // Register reset values.
  localparam logic [7:0] FAST_THR_RST  = 8'd80;
  localparam logic [7:0] MED_THR_RST   = 8'd50;
  localparam logic [7:0] SLOW_STEP_RST = 8'd1;
  localparam logic [7:0] FAST_STEP_RST = 8'd15;
  localparam logic [7:0] POS_MOD_RST   = 8'd60;

  // Tally limits and the hit count ceiling.
  localparam logic signed [7:0] TALLY_MAX = 8'sd127;
  localparam logic signed [7:0] TALLY_MIN = -8'sd128;
  localparam logic [1:0]        HITS_MAX  = 2'd3;
  localparam logic [1:0]        HITS_FAST = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_FAST     = 2'd2,
    MODE_SLOW     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_SLOW = 2'd1,
    EV_FAST = 2'd2
  } ev_e;

  typedef enum logic [2:0] {
    REG_FAST_THR  = 3'd0,
    REG_MED_THR   = 3'd1,
    REG_SLOW_STEP = 3'd2,
    REG_FAST_STEP = 3'd3,
    REG_POS_MOD   = 3'd4
  } reg_idx_e;

  // Configuration register file.
  typedef struct packed {
    logic [7:0] fast_thr;
    logic [7:0] med_thr;
    logic [7:0] slow_step;
    logic [7:0] fast_step;
    logic [7:0] pos_mod;
  } pgc_cfg_t;

  // Classifier result for one window.
  typedef struct packed {
    mode_e             mode;
    logic [1:0]        hits;
    logic signed [7:0] tally;
    logic              dir_up;
    ev_e               ev;
    logic [7:0]        mag;
  } pgc_cls_t;

endpackage

/* rtl/core/pgc_classify.sv */
// Magnitude, direction tally and pulse classifier state machine for one window.
module pgc_classify #(
  parameter int unsigned COUNT_WIDTH = pgc_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0] cnt_pos_i,
  input  logic [COUNT_WIDTH-1:0] cnt_neg_i,
  input  pgc_pkg::mode_e         mode_i,
  input  logic [1:0]             hits_i,
  input  logic signed [7:0]      tally_i,
  input  pgc_pkg::pgc_cfg_t      cfg_i,
  output pgc_pkg::pgc_cls_t      cls_o
);
  import pgc_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  logic [COUNT_WIDTH-1:0] mag;
  logic [CmpW-1:0]        mag_ext;
  logic                   any_cnt;
  logic                   fwd;
  logic                   gt_fast;
  logic                   gt_med;
  logic                   nz;
  logic [1:0]             hits_inc;
  logic signed [7:0]      tally_upd;
  mode_e                  mode_d;
  logic [1:0]             hits_d;
  ev_e                    ev;

  // Net magnitude and the direction of this window.
  assign any_cnt = (cnt_pos_i != '0) || (cnt_neg_i != '0);
  assign fwd     = cnt_pos_i > cnt_neg_i;
  assign mag     = fwd ? (cnt_pos_i - cnt_neg_i) : (cnt_neg_i - cnt_pos_i);
  assign mag_ext = CmpW'(mag);
  assign gt_fast = mag_ext > CmpW'(cfg_i.fast_thr);
  assign gt_med  = mag_ext > CmpW'(cfg_i.med_thr);
  assign nz      = mag != '0;

  // Saturating direction tally; equal nonzero counts still count down.
  always_comb begin
    tally_upd = tally_i;
    if (any_cnt) begin
      if (fwd) begin
        if (tally_i != TALLY_MAX) tally_upd = tally_i + 8'sd1;
      end else begin
        if (tally_i != TALLY_MIN) tally_upd = tally_i - 8'sd1;
      end
    end
  end

  assign hits_inc = (hits_i == HITS_MAX) ? HITS_MAX : hits_i + 2'd1;

  // Next mode, hit count and event.
  always_comb begin
    mode_d = mode_i;
    hits_d = hits_i;
    ev     = EV_NONE;
    unique case (mode_i)
      MODE_IDLE: begin
        if (gt_fast) begin
          mode_d = MODE_FAST;
        end else if (nz) begin
          if (gt_med) hits_d = hits_inc;
          mode_d = MODE_DEBOUNCE;
        end
      end
      MODE_DEBOUNCE: begin
        if (gt_fast) begin
          mode_d = MODE_FAST;
        end else if (nz) begin
          if (gt_med) begin
            hits_d = hits_inc;
            mode_d = (hits_inc >= HITS_FAST) ? MODE_FAST : MODE_SLOW;
          end else begin
            hits_d = 2'd0;
            mode_d = MODE_SLOW;
          end
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_SLOW: begin
        if (gt_fast) begin
          mode_d = MODE_FAST;
        end else if (gt_med) begin
          hits_d = hits_inc;
          if (hits_inc >= HITS_FAST) mode_d = MODE_FAST;
        end else if (nz) begin
          hits_d = 2'd0;
        end else begin
          ev     = EV_SLOW;
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        if (!nz) begin
          ev     = EV_FAST;
          mode_d = MODE_IDLE;
        end
      end
    endcase
  end

  // An event clears the tally and the hit count.
  always_comb begin
    cls_o.mode   = mode_d;
    cls_o.hits   = (ev != EV_NONE) ? 2'd0 : hits_d;
    cls_o.tally  = (ev != EV_NONE) ? 8'sd0 : tally_upd;
    cls_o.dir_up = tally_upd > 8'sd0;
    cls_o.ev     = ev;
    cls_o.mag    = (mag_ext > CmpW'(8'hFF)) ? 8'hFF : mag_ext[7:0];
  end

endmodule

/* rtl/core/pgc_position.sv */
// Position update by the slow or fast step with a single modulus wrap.
module pgc_position (
  input  logic [7:0]        pos_i,
  input  pgc_pkg::ev_e      ev_i,
  input  logic              dir_up_i,
  input  pgc_pkg::pgc_cfg_t cfg_i,
  output logic [7:0]        pos_o
);
  import pgc_pkg::*;

  logic [7:0]        step;
  logic signed [9:0] pos_s;
  logic signed [9:0] step_s;
  logic signed [9:0] mod_s;
  logic signed [9:0] p_raw;
  logic signed [9:0] p_wrap;

  assign step   = (ev_i == EV_SLOW) ? cfg_i.slow_step : cfg_i.fast_step;
  assign pos_s  = signed'({2'b00, pos_i});
  assign step_s = signed'({2'b00, step});
  assign mod_s  = signed'({2'b00, cfg_i.pos_mod});
  assign p_raw  = dir_up_i ? (pos_s + step_s) : (pos_s - step_s);

  // Wrap at most once into the modulus range.
  always_comb begin
    if (p_raw < 10'sd0) begin
      p_wrap = p_raw + mod_s;
    end else if (p_raw >= mod_s) begin
      p_wrap = p_raw - mod_s;
    end else begin
      p_wrap = p_raw;
    end
  end

  assign pos_o = (ev_i != EV_NONE) ? p_wrap[7:0] : pos_i;

endmodule

/* rtl/core/pulse_gesture_classifier.sv */
// Top level of the pulse gesture classifier with stream ports and register file.
//
// The block takes one window of forward and backward encoder counts per item
// and returns one result item per window: the event kind, the position after
// the window and the saturated net magnitude. It accepts one item every clock
// cycle while the result stream does not stall. An item is captured in an
// input register, then the classifier and position update run as one
// combinational pass into the result register, where the state registers
// are updated too. A stalled result holds in the result register while one
// more item waits in the input register. Registers are to be written by the
// user through the plain write port while no item is in flight; the block does not enforce it.
`include "assert_macros.svh"

module pulse_gesture_classifier #(
  parameter int unsigned COUNT_WIDTH = pgc_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned InW        = ((2 * COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Configuration write port.
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [7:0]     cfg_wdata_i,
  // Input stream.
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [InW-1:0] s_axis_tdata,  // counts_negative, counts_positive
  // Result stream.
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [15:0]    m_axis_tdata,  // magnitude_out, position_out
  output logic [1:0]     m_axis_tuser   // event_kind
);
  import pgc_pkg::*;

  pgc_cfg_t               cfg_q;
  logic                   in_v_q;
  logic [COUNT_WIDTH-1:0] cp_q;
  logic [COUNT_WIDTH-1:0] cn_q;
  logic                   out_v_q;
  ev_e                    ev_q;
  logic [7:0]             mag_q;
  mode_e                  mode_q;
  logic [1:0]             hits_q;
  logic signed [7:0]      tally_q;
  logic [7:0]             pos_q;
  logic [7:0]             pos_d;
  pgc_cls_t               cls;
  logic                   out_ready;
  logic                   advance;
  logic                   in_load;

  // Handshake between the input register and the result register.
  assign out_ready     = !out_v_q || m_axis_tready;
  assign advance       = in_v_q && out_ready;
  assign s_axis_tready = !in_v_q || out_ready;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_thr  <= FAST_THR_RST;
      cfg_q.med_thr   <= MED_THR_RST;
      cfg_q.slow_step <= SLOW_STEP_RST;
      cfg_q.fast_step <= FAST_STEP_RST;
      cfg_q.pos_mod   <= POS_MOD_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FAST_THR:  cfg_q.fast_thr  <= cfg_wdata_i;
        REG_MED_THR:   cfg_q.med_thr   <= cfg_wdata_i;
        REG_SLOW_STEP: cfg_q.slow_step <= cfg_wdata_i;
        REG_FAST_STEP: cfg_q.fast_step <= cfg_wdata_i;
        REG_POS_MOD:   cfg_q.pos_mod   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_load) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cp_q <= s_axis_tdata[COUNT_WIDTH-1:0];
      cn_q <= s_axis_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    end
  end

  pgc_classify #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_classify (
    .cnt_pos_i(cp_q),
    .cnt_neg_i(cn_q),
    .mode_i   (mode_q),
    .hits_i   (hits_q),
    .tally_i  (tally_q),
    .cfg_i    (cfg_q),
    .cls_o    (cls)
  );

  pgc_position u_position (
    .pos_i   (pos_q),
    .ev_i    (cls.ev),
    .dir_up_i(cls.dir_up),
    .cfg_i   (cfg_q),
    .pos_o   (pos_d)
  );

  // Classifier state register and the other per-block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      hits_q  <= 2'd0;
      tally_q <= 8'sd0;
      pos_q   <= 8'd0;
    end else if (advance) begin
      mode_q  <= cls.mode;
      hits_q  <= cls.hits;
      tally_q <= cls.tally;
      pos_q   <= pos_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q  <= cls.ev;
      mag_q <= cls.mag;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {mag_q, pos_q};
  assign m_axis_tuser  = ev_q;

  // Assertions.
  `PGC_ASSERT(a_no_reserved_ev, !m_axis_tvalid || (m_axis_tuser != 2'b11), "reserved event kind")
  `PGC_ASSERT(a_full_stall, !(in_v_q && out_v_q && !m_axis_tready) || !s_axis_tready, "accept while full")
  `PGC_ASSERT_NEXT(a_ev_clears, advance && (cls.ev != EV_NONE), (tally_q == 8'sd0) && (hits_q == 2'd0) && (mode_q == MODE_IDLE), "event did not clear state")

endmodule
